// ===== rtl/dmgr_pkg.sv =====
// ----------------------------------------------------------------------------
// dmgr_pkg
// shared types, constants and helpers for the dual monod growth datapath
// ----------------------------------------------------------------------------
package dmgr_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 16;

  // 0.727, 0.65 and 0.1 rounded to nearest at 16 fraction bits
  localparam logic [15:0] CO2Evo   = 16'd47645;
  localparam logic [15:0] CSucrose = 16'd42598;
  localparam logic [12:0] CTenth   = 13'd6554;

  typedef enum logic [2:0] {
    REG_MAX_GROWTH = 3'd0,
    REG_LIGHT_K    = 3'd1,
    REG_CO2_K      = 3'd2,
    REG_INV_YIELD  = 3'd3,
    REG_MAINT      = 3'd4,
    REG_DECAY      = 3'd5,
    REG_EXPORT     = 3'd6,
    REG_GROWTH     = 3'd7
  } reg_idx_e;

  // one restoring divider lane
  typedef struct packed {
    logic [32:0] r;
    logic [32:0] d;
    logic [15:0] q;
    logic        kz;
    logic        nz;
  } mono_t;

  typedef struct packed {
    mono_t       ml;
    mono_t       mc;
    logic [31:0] dens;
    logic        act;
  } div_stage_t;

  function automatic mono_t mono_init(logic [31:0] x, logic [31:0] k);
    mono_t o;
    o.r  = {1'b0, x};
    o.d  = {1'b0, k} + {1'b0, x};
    o.q  = '0;
    o.kz = (k == '0);
    o.nz = (x != '0);
    return o;
  endfunction

  // two quotient bits
  function automatic mono_t mono_step(mono_t a);
    mono_t       o;
    logic [33:0] t;
    o = a;
    for (int i = 0; i < 2; i++) begin
      t = {o.r, 1'b0};
      if (t >= {1'b0, o.d}) begin
        o.r = 33'(t - {1'b0, o.d});
        o.q = {o.q[14:0], 1'b1};
      end else begin
        o.r = t[32:0];
        o.q = {o.q[14:0], 1'b0};
      end
    end
    return o;
  endfunction

  // zero affinity gives one or zero
  function automatic logic [16:0] mono_ratio(mono_t a);
    logic [16:0] v;
    if (a.kz) begin
      v = a.nz ? 17'h10000 : 17'h00000;
    end else begin
      v = {1'b0, a.q};
    end
    return v;
  endfunction

  function automatic logic [47:0] clamp48(logic [64:0] v);
    logic [47:0] o;
    if (v[64:48] != '0) begin
      o = '1;
    end else begin
      o = v[47:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] sat_mag(logic [47:0] mag, logic neg);
    logic [31:0] o;
    if (neg) begin
      o = (mag >= 48'h8000_0000) ? 32'h8000_0000 : 32'(~mag[31:0] + 32'd1);
    end else begin
      o = (mag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] sat50(logic signed [49:0] v);
    logic [31:0] o;
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      o = 32'h7FFF_FFFF;
    end else if (v < -50'sh0_0000_8000_0000) begin
      o = 32'h8000_0000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

endpackage

// ===== rtl/dual_monod_growth_reaction.sv =====
// ----------------------------------------------------------------------------
// dual_monod_growth_reaction
// per-cell dual monod growth rate and reaction deltas, fixed point q16.16
// ----------------------------------------------------------------------------
// One grid cell word enters per clock while the output is not stalled; the
// pipeline holds 17 words and a stall of the output only halts the stages
// that are full, so bubbles close up. The length is set by the two restoring
// dividers for the monod ratios (two quotient bits per stage, eight stages)
// followed by nine stages of split multiplies and saturation.
// Configuration is read straight from the register file and must only be
// written while the pipeline is empty.
module dual_monod_growth_reaction (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // light_level, co2_level, density
  input  logic         s_axis_tuser,  // cell_active
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // uptake, o2, sucrose, cell_growth_rate
);

  localparam int unsigned NStg = 17;
  localparam int unsigned NDiv = 8;

  logic [31:0] mgr_q, kl_q, kc_q, iy_q, maint_q, decay_q, ef_q, gf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mgr_q   <= 32'd0;
      kl_q    <= 32'd65536;
      kc_q    <= 32'd65536;
      iy_q    <= 32'd65536;
      maint_q <= 32'd0;
      decay_q <= 32'd0;
      ef_q    <= 32'hFFFF_EB64;
      gf_q    <= 32'd68223;
    end else if (cfg_we_i) begin
      case (dmgr_pkg::reg_idx_e'(cfg_idx_i))
        dmgr_pkg::REG_MAX_GROWTH: mgr_q   <= cfg_data_i;
        dmgr_pkg::REG_LIGHT_K:    kl_q    <= cfg_data_i;
        dmgr_pkg::REG_CO2_K:      kc_q    <= cfg_data_i;
        dmgr_pkg::REG_INV_YIELD:  iy_q    <= cfg_data_i;
        dmgr_pkg::REG_MAINT:      maint_q <= cfg_data_i;
        dmgr_pkg::REG_DECAY:      decay_q <= cfg_data_i;
        dmgr_pkg::REG_EXPORT:     ef_q    <= cfg_data_i;
        dmgr_pkg::REG_GROWTH:     gf_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] adv;

  always_comb begin
    adv[NStg-1] = !v_q[NStg-1] || m_axis_tready;
    for (int k = NStg - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // divider stages
  dmgr_pkg::div_stage_t dv_q [NDiv];
  dmgr_pkg::div_stage_t dv_d [NDiv];

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    dmgr_pkg::div_stage_t src;
    if (k == 0) begin : g_first
      always_comb begin
        src.ml   = dmgr_pkg::mono_init(s_axis_tdata[31:0], kl_q);
        src.mc   = dmgr_pkg::mono_init(s_axis_tdata[63:32], kc_q);
        src.dens = s_axis_tdata[95:64];
        src.act  = s_axis_tuser;
      end
    end else begin : g_next
      assign src = dv_q[k-1];
    end
    always_comb begin
      dv_d[k]    = src;
      dv_d[k].ml = dmgr_pkg::mono_step(src.ml);
      dv_d[k].mc = dmgr_pkg::mono_step(src.mc);
    end
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // stage 8: first monod product
  logic [16:0] rl_d, rc_d, rc_q;
  logic [48:0] m1_d;
  logic [31:0] mu1_q, dens8_q;
  logic        act8_q;

  assign rl_d = dmgr_pkg::mono_ratio(dv_q[NDiv-1].ml);
  assign rc_d = dmgr_pkg::mono_ratio(dv_q[NDiv-1].mc);
  assign m1_d = mgr_q * rl_d;

  // stage 9: growth rate mu
  logic [48:0] mu_d;
  logic [31:0] mu9_q, dens9_q;
  logic        act9_q;

  assign mu_d = mu1_q * rc_q;

  // stage 10: export product, gross growth and constant scalings
  logic        efneg_d;
  logic [31:0] efmag_d;
  logic [63:0] t3p_d, gpp_d;
  logic [47:0] k1p_d, k2p_d;
  logic [44:0] k3p_d;
  logic [31:0] mu10_q, k1_10_q, k2_10_q, dens10_q;
  logic [47:0] t3m10_q, gp10_q;
  logic [28:0] k3_10_q;
  logic        t3neg10_q, act10_q;

  assign efneg_d = ef_q[31];
  assign efmag_d = efneg_d ? 32'(~ef_q + 32'd1) : ef_q;
  assign t3p_d   = mu9_q * efmag_d;
  assign gpp_d   = mu9_q * gf_q;
  assign k1p_d   = dmgr_pkg::CO2Evo * iy_q;
  assign k2p_d   = dmgr_pkg::CSucrose * iy_q;
  assign k3p_d   = dmgr_pkg::CTenth * maint_q;

  // stage 11: mu plus export term, net growth
  logic signed [49:0] t3s_d, ssum_d, grw_d;
  logic [49:0]        sabs_d;
  logic [48:0]        smag11_q;
  logic               sneg11_q, t3neg11_q, act11_q;
  logic [47:0]        t3m11_q;
  logic [31:0]        k1_11_q, k2_11_q, gr11_q, dens11_q;
  logic [28:0]        k3_11_q;

  always_comb begin
    t3s_d  = t3neg10_q ? -$signed({2'b00, t3m10_q}) : $signed({2'b00, t3m10_q});
    ssum_d = $signed({18'd0, mu10_q}) + t3s_d;
    sabs_d = ssum_d[49] ? 50'(-ssum_d) : 50'(ssum_d);
    grw_d  = $signed({2'b00, gp10_q}) - $signed({18'd0, decay_q})
           - $signed({18'd0, maint_q});
  end

  // stage 12: yield products, split in two halves
  logic [55:0] pul_d, pol_d, psl_d;
  logic [56:0] puh_d, poh_d;
  logic [55:0] psh_d;
  logic [60:0] bmp_d;
  logic [55:0] pul_q, pol_q, psl_q, psh_q;
  logic [56:0] puh_q, poh_q;
  logic [44:0] bm12_q;
  logic [31:0] gr12_q, dens12_q;
  logic        sneg12_q, t3neg12_q, act12_q;

  assign pul_d = iy_q * smag11_q[23:0];
  assign puh_d = iy_q * smag11_q[48:24];
  assign pol_d = k1_11_q * smag11_q[23:0];
  assign poh_d = k1_11_q * smag11_q[48:24];
  assign psl_d = k2_11_q * t3m11_q[23:0];
  assign psh_d = k2_11_q * t3m11_q[47:24];
  assign bmp_d = k3_11_q * dens11_q;

  // stage 13: combine halves, shift and clamp
  logic [80:0] su_d, so_d, ss_d;
  logic [47:0] au13_q, ao13_q, as13_q;
  logic [44:0] bm13_q;
  logic [31:0] gr13_q, dens13_q;
  logic        sneg13_q, t3neg13_q, act13_q;

  assign su_d = {puh_q, 24'd0} + {24'd0, pul_q};
  assign so_d = {poh_q, 24'd0} + {24'd0, pol_q};
  assign ss_d = {1'b0, psh_q, 24'd0} + {25'd0, psl_q};

  // stage 14: density products, split in two halves
  logic [55:0] qul_d, quh_d, qol_d, qoh_d, qsl_d, qsh_d;
  logic [55:0] qul_q, quh_q, qol_q, qoh_q, qsl_q, qsh_q;
  logic [44:0] bm14_q;
  logic [31:0] gr14_q;
  logic        sneg14_q, t3neg14_q, act14_q;

  assign qul_d = au13_q[23:0] * dens13_q;
  assign quh_d = au13_q[47:24] * dens13_q;
  assign qol_d = ao13_q[23:0] * dens13_q;
  assign qoh_d = ao13_q[47:24] * dens13_q;
  assign qsl_d = as13_q[23:0] * dens13_q;
  assign qsh_d = as13_q[47:24] * dens13_q;

  // stage 15: combine halves, shift and clamp
  logic [80:0] fu_d, fo_d, fs_d;
  logic [47:0] fu15_q, fo15_q, fs15_q;
  logic [44:0] bm15_q;
  logic [31:0] gr15_q;
  logic        sneg15_q, t3neg15_q, act15_q;

  assign fu_d = {1'b0, quh_q, 24'd0} + {25'd0, qul_q};
  assign fo_d = {1'b0, qoh_q, 24'd0} + {25'd0, qol_q};
  assign fs_d = {1'b0, qsh_q, 24'd0} + {25'd0, qsl_q};

  // stage 16: sign, maintenance term, saturation, masking
  logic signed [49:0] o2v_d;
  logic [31:0]        up_d, o2_d, suc_d;
  logic [127:0]       out_q;
  logic               act16_q;

  always_comb begin
    o2v_d = sneg15_q ? -$signed({2'b00, fo15_q}) : $signed({2'b00, fo15_q});
    o2v_d = o2v_d - $signed({5'd0, bm15_q});
    up_d  = act15_q ? dmgr_pkg::sat_mag(fu15_q, !sneg15_q) : 32'd0;
    o2_d  = act15_q ? dmgr_pkg::sat50(o2v_d) : 32'd0;
    suc_d = act15_q ? dmgr_pkg::sat_mag(fs15_q, t3neg15_q) : 32'd0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      mu1_q   <= m1_d[47:16];
      rc_q    <= rc_d;
      dens8_q <= dv_q[NDiv-1].dens;
      act8_q  <= dv_q[NDiv-1].act;
    end
    if (adv[9]) begin
      mu9_q   <= mu_d[47:16];
      dens9_q <= dens8_q;
      act9_q  <= act8_q;
    end
    if (adv[10]) begin
      mu10_q    <= mu9_q;
      t3m10_q   <= t3p_d[63:16];
      t3neg10_q <= efneg_d;
      gp10_q    <= gpp_d[63:16];
      k1_10_q   <= k1p_d[47:16];
      k2_10_q   <= k2p_d[47:16];
      k3_10_q   <= k3p_d[44:16];
      dens10_q  <= dens9_q;
      act10_q   <= act9_q;
    end
    if (adv[11]) begin
      smag11_q  <= sabs_d[48:0];
      sneg11_q  <= ssum_d[49];
      t3m11_q   <= t3m10_q;
      t3neg11_q <= t3neg10_q;
      k1_11_q   <= k1_10_q;
      k2_11_q   <= k2_10_q;
      k3_11_q   <= k3_10_q;
      gr11_q    <= dmgr_pkg::sat50(grw_d);
      dens11_q  <= dens10_q;
      act11_q   <= act10_q;
    end
    if (adv[12]) begin
      pul_q     <= pul_d;
      puh_q     <= puh_d;
      pol_q     <= pol_d;
      poh_q     <= poh_d;
      psl_q     <= psl_d;
      psh_q     <= psh_d;
      bm12_q    <= bmp_d[60:16];
      gr12_q    <= gr11_q;
      dens12_q  <= dens11_q;
      sneg12_q  <= sneg11_q;
      t3neg12_q <= t3neg11_q;
      act12_q   <= act11_q;
    end
    if (adv[13]) begin
      au13_q    <= dmgr_pkg::clamp48(su_d[80:16]);
      ao13_q    <= dmgr_pkg::clamp48(so_d[80:16]);
      as13_q    <= dmgr_pkg::clamp48(ss_d[80:16]);
      bm13_q    <= bm12_q;
      gr13_q    <= gr12_q;
      dens13_q  <= dens12_q;
      sneg13_q  <= sneg12_q;
      t3neg13_q <= t3neg12_q;
      act13_q   <= act12_q;
    end
    if (adv[14]) begin
      qul_q     <= qul_d;
      quh_q     <= quh_d;
      qol_q     <= qol_d;
      qoh_q     <= qoh_d;
      qsl_q     <= qsl_d;
      qsh_q     <= qsh_d;
      bm14_q    <= bm13_q;
      gr14_q    <= gr13_q;
      sneg14_q  <= sneg13_q;
      t3neg14_q <= t3neg13_q;
      act14_q   <= act13_q;
    end
    if (adv[15]) begin
      fu15_q    <= dmgr_pkg::clamp48(fu_d[80:16]);
      fo15_q    <= dmgr_pkg::clamp48(fo_d[80:16]);
      fs15_q    <= dmgr_pkg::clamp48(fs_d[80:16]);
      bm15_q    <= bm14_q;
      gr15_q    <= gr14_q;
      sneg15_q  <= sneg14_q;
      t3neg15_q <= t3neg14_q;
      act15_q   <= act14_q;
    end
    if (adv[16]) begin
      out_q   <= {gr15_q, suc_d, o2_d, up_d};
      act16_q <= act15_q;
    end
  end

  assign m_axis_tvalid = v_q[NStg-1];
  assign m_axis_tdata  = out_q;

  // co2 monod ratio never exceeds one
  a_ratio_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[8] |-> (rc_q <= 17'h10000))
    else $error("co2 ratio above one");

  // mu never exceeds the maximum growth rate
  a_mu_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[9] |-> (mu9_q <= mgr_q))
    else $error("growth rate above maximum");

  // inactive cell leaves the reaction deltas at zero
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NStg-1] && !act16_q) |-> (out_q[95:0] == 96'd0))
    else $error("nonzero delta for inactive cell");

endmodule
